### design/fsa_pkg.sv
// Package for the frequency stability averager.
// Holds widths, register indexes, request codes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none

package fsa_pkg;

  localparam int FREQ_W     = 32;
  localparam int COUNT_W    = 8;
  localparam int DIVIDEND_W = FREQ_W + COUNT_W;
  localparam int DIVISOR_W  = COUNT_W + 1;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED  = 1'd1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic STATUS_WAITING = 1'b0;
  localparam logic STATUS_STABLE  = 1'b1;

  localparam logic [FREQ_W-1:0]  TOLERANCE_RESET = 32'd100;
  localparam logic [COUNT_W-1:0] REQUIRED_RESET  = 8'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_DECIDE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } fsa_state_t;

endpackage

`default_nettype wire

### design/frequency_stability_averager_unit.sv
// Path: a clear, a restart or a sample at the count limit passes the gap and decision steps and is
// loaded into the output register in the done step. A sample folded into the mean passes gap and
// decision, product and sum, 40 bit-serial divider steps, write-back and the output load.
// Flow: one item at a time; the next input transfer waits until the result is loaded, and
// waits longer while the output register still holds an untaken result.
// Reset: synchronous, clears reference and count, tolerance to 100 and required count to 8.
`default_nettype none

module frequency_stability_averager_unit
  import fsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FREQ_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 req_type,
  input  wire logic [FREQ_W-1:0]    meas_freq,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      status,
  output logic [FREQ_W-1:0]         stable_frequency,
  output logic [COUNT_W-1:0]        agree_count
);

  fsa_state_t state, state_next;

  logic [FREQ_W-1:0]     tolerance_hz;
  logic [COUNT_W-1:0]    required_samples;
  logic [FREQ_W-1:0]     reference_frequency;
  logic [COUNT_W-1:0]    sample_count;
  logic                  req;
  logic [FREQ_W-1:0]     freq;
  logic [FREQ_W-1:0]     gap;
  logic [DIVIDEND_W-1:0] acc;

  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic [DIVIDEND_W-1:0] dividend;
  logic                  out_load;
  logic                  restart;
  logic                  fold;

  assign restart  = (sample_count == '0) || (gap > tolerance_hz);
  assign fold     = (sample_count < required_samples);
  assign dividend = acc + {{COUNT_W{1'b0}}, freq};

  fsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  ({1'b0, sample_count} + 1'b1),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_hz     <= TOLERANCE_RESET;
      required_samples <= REQUIRED_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TOLERANCE: tolerance_hz     <= cfg_data;
        REG_REQUIRED:  required_samples <= cfg_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_GAP;
      ST_GAP:    state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (req == REQ_SAMPLE && !restart && fold) state_next = ST_MUL;
        else state_next = ST_DONE;
      end
      ST_MUL:    state_next = ST_ADD;
      ST_ADD:    state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    div_start = (state == ST_ADD);
    out_load  = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      reference_frequency <= '0;
      sample_count        <= '0;
      out_valid           <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DECIDE) begin
        priority if (req == REQ_CLEAR) begin
          reference_frequency <= '0;
          sample_count        <= '0;
        end else if (restart) begin
          reference_frequency <= freq;
          sample_count        <= COUNT_W'(1);
        end
      end else if (div_done) begin
        reference_frequency <= div_quotient[FREQ_W-1:0];
        sample_count        <= sample_count + 1'b1;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload: hold the transfer, the gap, the product and the output result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req  <= req_type;
      freq <= meas_freq;
    end
    if (state == ST_GAP) begin
      gap <= (freq >= reference_frequency) ? freq - reference_frequency
                                           : reference_frequency - freq;
    end
    if (state == ST_MUL) begin
      acc <= {{COUNT_W{1'b0}}, reference_frequency} * {{FREQ_W{1'b0}}, sample_count};
    end
    if (out_load) begin
      status           <= (sample_count >= required_samples) ? STATUS_STABLE : STATUS_WAITING;
      stable_frequency <= reference_frequency;
      agree_count      <= sample_count;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   sample_count == '0 |-> reference_frequency == '0)
    else $error("empty count with non-zero reference");
  assert property (@(posedge clk) disable iff (rst)
                   state == ST_DIV |-> sample_count != '0 && sample_count < required_samples)
    else $error("mean fold outside the count range");
  assert property (@(posedge clk) disable iff (rst)
                   div_done |-> state == ST_DIV && !div_start)
    else $error("divider finished outside the divide step");
  assert property (@(posedge clk) disable iff (rst)
                   state == ST_DIV |-> div_busy || div_done)
    else $error("divide step without a running divider");
  assert property (@(posedge clk) disable iff (rst)
                   $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done step");

endmodule

`default_nettype wire

### design/fsa_div.sv
// Bit-serial restoring divider: 40-bit dividend by 9-bit divisor, one quotient bit a cycle.
// Depends on fsa_pkg for widths.
`default_nettype none

module fsa_div
  import fsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  logic [COUNT_W-1:0]   rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [STEP_W-1:0]    steps;
  logic [DIVISOR_W-1:0] trial;
  logic [DIVISOR_W-1:0] trial_diff;
  logic                 fits;

  assign trial      = {rem, quotient[DIVIDEND_W-1]};
  assign fits       = (trial >= dvs);
  assign trial_diff = trial - dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift one dividend bit into the remainder and keep the trial subtraction when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy && $past(busy))
    else $error("divider done without a finished run");
  assert property (@(posedge clk) disable iff (rst) busy && !start |-> {1'b0, rem} < dvs)
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### tb/frequency_stability_averager_unit_tb.sv
// Testbench for frequency_stability_averager_unit: directed and random sample streams,
// checked against a cycle-free prediction of the reference mean and the agreeing count.
// Depends on fsa_pkg and the RTL of the unit.

module frequency_stability_averager_unit_tb
  import fsa_pkg::*;
();

  typedef struct packed {
    logic               status;
    logic [FREQ_W-1:0]  hz;
    logic [COUNT_W-1:0] agreed;
  } reading_t;

  // Tracks the running reference and the count, and holds the readings still owed.
  class averager_tracker;
    logic [FREQ_W-1:0]  tolerance;
    logic [COUNT_W-1:0] required;
    logic [FREQ_W-1:0]  mean_hz;
    logic [COUNT_W-1:0] agreed;
    reading_t           pending[$];
    int unsigned        failures;

    function new();
      tolerance = TOLERANCE_RESET;
      required  = REQUIRED_RESET;
      mean_hz   = '0;
      agreed    = '0;
      failures  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] data);
      case (idx)
        REG_TOLERANCE: tolerance = data;
        REG_REQUIRED:  required  = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic rq, logic [FREQ_W-1:0] f);
      logic [FREQ_W-1:0]     gap;
      logic [DIVIDEND_W-1:0] total;
      reading_t              r;
      gap = (f >= mean_hz) ? f - mean_hz : mean_hz - f;
      if (rq == REQ_CLEAR) begin
        mean_hz = '0;
        agreed  = '0;
      end else if (agreed == 0 || gap > tolerance) begin
        mean_hz = f;
        agreed  = COUNT_W'(1);
      end else if (agreed < required) begin
        // fold into the mean; the product needs the full dividend width
        total   = DIVIDEND_W'(mean_hz) * DIVIDEND_W'(agreed) + DIVIDEND_W'(f);
        mean_hz = FREQ_W'(total / (DIVIDEND_W'(agreed) + 1));
        agreed  = agreed + 1'b1;
      end
      r.status = (agreed >= required) ? STATUS_STABLE : STATUS_WAITING;
      r.hz     = mean_hz;
      r.agreed = agreed;
      pending.push_back(r);
    endfunction

    function void check_reading(logic st, logic [FREQ_W-1:0] hz, logic [COUNT_W-1:0] cnt);
      reading_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: status %0d frequency %0d count %0d",
                 $time, st, hz, cnt);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        failures++;
      end
      if (hz !== want.hz) begin
        $display("%0t: stable_frequency expected %0d actual %0d", $time, want.hz, hz);
        failures++;
      end
      if (cnt !== want.agreed) begin
        $display("%0t: agree_count expected %0d actual %0d", $time, want.agreed, cnt);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TOLERANCE;
  logic [FREQ_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = REQ_SAMPLE;
  logic [FREQ_W-1:0]    meas_freq = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 status;
  logic [FREQ_W-1:0]    stable_frequency;
  logic [COUNT_W-1:0]   agree_count;

  bit              steady = 1'b0;
  averager_tracker tracker = new();

  frequency_stability_averager_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .meas_freq        (meas_freq),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .stable_frequency (stable_frequency),
    .agree_count      (agree_count)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; none while steady.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 70);
  endfunction

  // Keep valid high across back-to-back transfers; drop it only for a gap.
  task automatic send_item(input logic rq, input logic [FREQ_W-1:0] f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rq;
    meas_freq <= f;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(rq, f);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [FREQ_W-1:0] tol, input logic [COUNT_W-1:0] need);
    logic [FREQ_W-1:0] need_word;
    // upper bits of the count write are junk the block must drop
    need_word = $urandom;
    need_word[COUNT_W-1:0] = need;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TOLERANCE;
    cfg_data  <= tol;
    @(posedge clk);
    tracker.write_register(REG_TOLERANCE, tol);
    cfg_index <= REG_REQUIRED;
    cfg_data  <= need_word;
    @(posedge clk);
    tracker.write_register(REG_REQUIRED, need_word);
    cfg_wr_en <= 1'b0;
  endtask

  // Bursts of samples close to a base, with some noise and clears between them.
  task automatic run_phase(input int n);
    logic [FREQ_W-1:0] base;
    logic [FREQ_W-1:0] off;
    logic [FREQ_W:0]   sum;
    logic [FREQ_W-1:0] f;
    int                burst;
    int                pick;
    base  = '0;
    burst = 0;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(REQ_CLEAR, $urandom);
      end else if (pick < 12) begin
        send_item(REQ_SAMPLE, $urandom);
      end else begin
        if (burst == 0) begin
          pick = $urandom_range(0, 9);
          base = (pick == 0) ? FREQ_W'($urandom_range(0, 300)) :
                 (pick == 1) ? '1 - FREQ_W'($urandom_range(0, 300)) : FREQ_W'($urandom);
          burst = $urandom_range(1, int'(tracker.required) + 4);
        end
        burst--;
        off = $urandom_range(tracker.tolerance >> 1, 0);
        if ($urandom_range(0, 1)) begin
          sum = {1'b0, base} + off;
          f   = sum[FREQ_W] ? '1 : sum[FREQ_W-1:0];
        end else begin
          f = (off > base) ? '0 : base - off;
        end
        send_item(REQ_SAMPLE, f);
      end
    end
    settle();
  endtask

  // Output side: random stalls after each transfer, and two long hold-offs.
  initial begin
    int hold;
    int transfers;
    hold      = 0;
    transfers = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_reading(status, stable_frequency, agree_count);
        transfers++;
        hold = pick_gap();
        if (transfers == 100 || transfers == 500) hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [FREQ_W-1:0]  tol;
    logic [COUNT_W-1:0] need;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: tolerance 100, eight samples
    send_item(REQ_SAMPLE, 32'd1000);
    send_item(REQ_SAMPLE, 32'd1100);
    send_item(REQ_SAMPLE, 32'd1151);
    send_item(REQ_SAMPLE, 32'd1200);
    send_item(REQ_SAMPLE, 32'd1180);
    send_item(REQ_SAMPLE, 32'd1170);
    send_item(REQ_SAMPLE, 32'd1190);
    send_item(REQ_SAMPLE, 32'd1160);
    send_item(REQ_SAMPLE, 32'd1175);
    send_item(REQ_SAMPLE, 32'd1185);
    send_item(REQ_SAMPLE, 32'd1176);
    send_item(REQ_CLEAR, 32'hFFFF_FFFF);
    send_item(REQ_SAMPLE, 32'd0);
    send_item(REQ_SAMPLE, 32'd100);
    send_item(REQ_SAMPLE, 32'hFFFF_FFFF);
    send_item(REQ_SAMPLE, 32'hFFFF_FF9B);
    send_item(REQ_CLEAR, 32'hA5A5_A5A5);
    settle();

    // zero tolerance, zero required count: never folds, always stable
    set_config('0, '0);
    send_item(REQ_SAMPLE, 32'd5);
    send_item(REQ_SAMPLE, 32'd5);
    send_item(REQ_SAMPLE, 32'd6);
    send_item(REQ_CLEAR, 32'h5A5A_5A5A);
    settle();

    set_config('1, 8'd1);
    send_item(REQ_SAMPLE, 32'd0);
    send_item(REQ_SAMPLE, 32'hFFFF_FFFF);
    settle();

    // everything agrees: run the count up to its ceiling of 255 and hold there
    steady = 1'b1;
    set_config('1, 8'd255);
    repeat (262) send_item(REQ_SAMPLE, $urandom);
    settle();

    for (int p = 0; p < 8; p++) begin
      steady = (p % 4 == 3);
      case ($urandom_range(0, 5))
        0:       tol = '0;
        1:       tol = 32'd1;
        2:       tol = TOLERANCE_RESET;
        3:       tol = $urandom_range(2, 5000);
        4:       tol = '1;
        default: tol = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       need = '0;
        1:       need = 8'd1;
        2:       need = 8'd2;
        3:       need = REQUIRED_RESET;
        4:       need = (p == 5) ? 8'd255 : 8'd16;
        default: need = COUNT_W'($urandom_range(3, 20));
      endcase
      set_config(tol, need);
      run_phase(55);
    end

    repeat (50) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
